>>> rtl/ac3_fhd_pkg.sv
// package for the ac3 frame header decoder: payload types, constants and lookup tables
package ac3_fhd_pkg;

  // sync word and header layout
  localparam logic [7:0] SYNC_HIGH        = 8'h0B;
  localparam logic [7:0] SYNC_LOW         = 8'h77;
  localparam logic [3:0] MIN_SYNC_BYTES   = 4'd2;
  localparam logic [3:0] MIN_HEADER_BYTES = 4'd8;
  localparam logic [5:0] SIZE_CODES       = 6'd38;

  // sample-rate codes
  localparam logic [1:0] RATE_48K       = 2'd0;
  localparam logic [1:0] RATE_44K1      = 2'd1;
  localparam logic [1:0] RATE_32K       = 2'd2;
  localparam logic [1:0] RATE_RESERVED  = 2'd3;

  // channel modes that matter for the lfe bit position and service type
  localparam logic [2:0] MODE_DUAL_MONO = 3'd0;
  localparam logic [2:0] MODE_MONO      = 3'd1;
  localparam logic [2:0] MODE_STEREO    = 3'd2;

  // service modes
  localparam logic [2:0] SVC_KARAOKE    = 3'd7;
  localparam logic [2:0] SVC_FIRST_ASSOC = 3'd2;

  typedef struct packed {
    logic [3:0] bytes_available;
    logic [7:0] sync_byte_high;
    logic [7:0] sync_byte_low;
    logic [7:0] rate_size_byte;
    logic [7:0] stream_info_byte;
    logic [7:0] channel_mode_byte;
  } ac3_in_t;

  typedef struct packed {
    logic        sync_ok;
    logic        header_ok;
    logic [11:0] frame_bytes;
    logic [9:0]  kbit_rate;
    logic [1:0]  rate_code;
    logic [15:0] frame_micros;
    logic [4:0]  stream_version;
    logic [2:0]  service_mode;
    logic [2:0]  channel_mode;
    logic [2:0]  full_channels;
    logic        lfe_present;
    logic        main_service;
  } ac3_out_t;

  // nominal bitrate in kbit/s, one entry per pair of size codes
  function automatic logic [9:0] kbps_of_pair(input logic [4:0] pair);
    logic [9:0] r;
    case (pair)
      5'd0:    r = 10'd32;
      5'd1:    r = 10'd40;
      5'd2:    r = 10'd48;
      5'd3:    r = 10'd56;
      5'd4:    r = 10'd64;
      5'd5:    r = 10'd80;
      5'd6:    r = 10'd96;
      5'd7:    r = 10'd112;
      5'd8:    r = 10'd128;
      5'd9:    r = 10'd160;
      5'd10:   r = 10'd192;
      5'd11:   r = 10'd224;
      5'd12:   r = 10'd256;
      5'd13:   r = 10'd320;
      5'd14:   r = 10'd384;
      5'd15:   r = 10'd448;
      5'd16:   r = 10'd512;
      5'd17:   r = 10'd576;
      5'd18:   r = 10'd640;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // 44.1 khz frame size in words for the even code of each pair; odd code adds one
  function automatic logic [10:0] words_44k1_of_pair(input logic [4:0] pair);
    logic [10:0] w;
    case (pair)
      5'd0:    w = 11'd69;
      5'd1:    w = 11'd87;
      5'd2:    w = 11'd104;
      5'd3:    w = 11'd121;
      5'd4:    w = 11'd139;
      5'd5:    w = 11'd174;
      5'd6:    w = 11'd208;
      5'd7:    w = 11'd243;
      5'd8:    w = 11'd278;
      5'd9:    w = 11'd348;
      5'd10:   w = 11'd417;
      5'd11:   w = 11'd487;
      5'd12:   w = 11'd557;
      5'd13:   w = 11'd696;
      5'd14:   w = 11'd835;
      5'd15:   w = 11'd975;
      5'd16:   w = 11'd1114;
      5'd17:   w = 11'd1253;
      5'd18:   w = 11'd1393;
      default: w = 11'd0;
    endcase
    return w;
  endfunction

  // duration of 1536 samples in whole microseconds
  function automatic logic [15:0] micros_of_rate(input logic [1:0] fs);
    logic [15:0] m;
    case (fs)
      RATE_48K:  m = 16'd32000;
      RATE_44K1: m = 16'd34830;
      RATE_32K:  m = 16'd48000;
      default:   m = 16'd0;
    endcase
    return m;
  endfunction

  // full-bandwidth channel count per channel mode
  function automatic logic [2:0] channels_of_mode(input logic [2:0] mode);
    logic [2:0] c;
    case (mode)
      3'd0:    c = 3'd2;
      3'd1:    c = 3'd1;
      3'd2:    c = 3'd2;
      3'd3:    c = 3'd3;
      3'd4:    c = 3'd3;
      3'd5:    c = 3'd4;
      3'd6:    c = 3'd4;
      3'd7:    c = 3'd5;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/ac3_frame_header_decoder.sv
// ac3 sync frame header decoder: three-stage pipeline with valid/ready on both sides
//
// Takes the leading bytes of one AC-3 sync frame per transfer and returns one decoded
// header per transfer: sync word check, frame size in bytes, bitrate, frame duration in
// microseconds and the stream fields of bytes 5 and 6. One header can be accepted every
// clock cycle as long as the output takes them. There are three register stages (field
// decode, table lookup, output formatting), each of which stalls only when the stage
// after it is full and not draining, so back-pressure on the output loses and repeats
// nothing. Short headers give zero fields apart from the sync check; reserved or
// out-of-range codes zero only the size, rate and duration fields.
module ac3_frame_header_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ac3_fhd_pkg::ac3_in_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ac3_fhd_pkg::ac3_out_t out_data_o
);
  import ac3_fhd_pkg::*;

  typedef struct packed {
    logic       sync_ok;
    logic       long_ok;
    logic       header_ok;
    logic [1:0] fs;
    logic [5:0] sc;
    logic [4:0] ver;
    logic [2:0] svc;
    logic [2:0] mode;
    logic       lfe;
  } dec_t;

  typedef struct packed {
    logic        sync_ok;
    logic        header_ok;
    logic [1:0]  fs;
    logic [10:0] words;
    logic [9:0]  kbps;
    logic [15:0] micros;
    logic [4:0]  ver;
    logic [2:0]  svc;
    logic [2:0]  mode;
    logic [2:0]  chans;
    logic        lfe;
    logic        main;
  } look_t;

  logic     v1_q, v2_q, v3_q;
  logic     rdy1, rdy2, rdy3;
  dec_t     s1_d, s1_q;
  look_t    s2_d, s2_q;
  ac3_out_t s3_d, s3_q;

  // per-stage ready: a stage moves when empty or when the next one moves
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: slice fields, check sync, length and codes
  always_comb begin
    logic [1:0] drop;
    logic [2:0] shift;
    s1_d.sync_ok   = (in_data_i.bytes_available >= MIN_SYNC_BYTES) &&
                     (in_data_i.sync_byte_high == SYNC_HIGH) &&
                     (in_data_i.sync_byte_low == SYNC_LOW);
    s1_d.long_ok   = (in_data_i.bytes_available >= MIN_HEADER_BYTES);
    s1_d.fs        = in_data_i.rate_size_byte[7:6];
    s1_d.sc        = in_data_i.rate_size_byte[5:0];
    s1_d.header_ok = s1_d.long_ok && (s1_d.fs != RATE_RESERVED) && (s1_d.sc < SIZE_CODES);
    s1_d.ver       = s1_d.long_ok ? in_data_i.stream_info_byte[7:3] : 5'd0;
    s1_d.svc       = s1_d.long_ok ? in_data_i.stream_info_byte[2:0] : 3'd0;
    s1_d.mode      = s1_d.long_ok ? in_data_i.channel_mode_byte[7:5] : 3'd0;
    // lfe bit sits below zero, one or two 2-bit mix fields
    drop = 2'd0;
    if (s1_d.mode[0] && (s1_d.mode != MODE_MONO)) begin
      drop = drop + 2'd1;
    end
    if (s1_d.mode[2] || (s1_d.mode == MODE_STEREO)) begin
      drop = drop + 2'd1;
    end
    shift = 3'd4 - {drop, 1'b0};
    s1_d.lfe = s1_d.long_ok && in_data_i.channel_mode_byte[shift];
  end

  // stage 2: table lookups
  always_comb begin
    logic [4:0]  pair;
    logic [9:0]  kbps;
    logic [10:0] words;
    pair = s1_q.sc[5:1];
    kbps = kbps_of_pair(pair);
    case (s1_q.fs)
      RATE_48K:  words = {kbps, 1'b0};
      RATE_44K1: words = words_44k1_of_pair(pair) + {10'd0, s1_q.sc[0]};
      RATE_32K:  words = {1'b0, kbps} + {kbps, 1'b0};
      default:   words = 11'd0;
    endcase
    s2_d.sync_ok   = s1_q.sync_ok;
    s2_d.header_ok = s1_q.header_ok;
    s2_d.fs        = s1_q.fs;
    s2_d.words     = words;
    s2_d.kbps      = kbps;
    s2_d.micros    = micros_of_rate(s1_q.fs);
    s2_d.ver       = s1_q.ver;
    s2_d.svc       = s1_q.svc;
    s2_d.mode      = s1_q.mode;
    s2_d.chans     = s1_q.long_ok ? channels_of_mode(s1_q.mode) : 3'd0;
    s2_d.lfe       = s1_q.lfe;
    s2_d.main      = s1_q.long_ok &&
                     ((s1_q.svc < SVC_FIRST_ASSOC) ||
                      ((s1_q.svc == SVC_KARAOKE) && (s1_q.mode > MODE_MONO)));
  end

  // stage 3: byte count and zeroing of rejected headers
  always_comb begin
    s3_d.sync_ok        = s2_q.sync_ok;
    s3_d.header_ok      = s2_q.header_ok;
    s3_d.frame_bytes    = s2_q.header_ok ? {s2_q.words, 1'b0} : 12'd0;
    s3_d.kbit_rate      = s2_q.header_ok ? s2_q.kbps : 10'd0;
    s3_d.rate_code      = s2_q.header_ok ? s2_q.fs : RATE_48K;
    s3_d.frame_micros   = s2_q.header_ok ? s2_q.micros : 16'd0;
    s3_d.stream_version = s2_q.ver;
    s3_d.service_mode   = s2_q.svc;
    s3_d.channel_mode   = s2_q.mode;
    s3_d.full_channels  = s2_q.chans;
    s3_d.lfe_present    = s2_q.lfe;
    s3_d.main_service   = s2_q.main;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (rdy3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

  // a rejected header carries no size, rate or duration
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.header_ok) |->
      (out_data_o.frame_bytes == 12'd0 && out_data_o.kbit_rate == 10'd0 &&
       out_data_o.frame_micros == 16'd0 && out_data_o.rate_code == RATE_48K))
    else $error("rejected header with non-zero size fields");

  // an accepted header never reports the reserved rate and has a real size and channel count
  a_accept_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.header_ok) |->
      (out_data_o.rate_code != RATE_RESERVED && out_data_o.frame_bytes != 12'd0 &&
       out_data_o.full_channels != 3'd0))
    else $error("accepted header with bad rate, size or channel count");

  // a stalled pipeline keeps every stage full that was full
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && v2_q && !out_ready_i) |=> (v3_q && v2_q))
    else $error("stalled stage dropped a transfer");

  // input is refused only when every stage is full
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && !out_ready_i))
    else $error("input refused with room in the pipeline");

endmodule

>>> bench/ac3_frame_header_decoder_tb.sv
// testbench for the ac3 frame header decoder: directed and random headers, scoreboard check
`timescale 1ns / 100ps

module ac3_frame_header_decoder_tb;
  import ac3_fhd_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int HOLD_CYCLES    = 150;
  localparam int HOLD_ITEMS     = 40;
  localparam int PHASE_ITEMS    = 560;
  localparam int FRAME_SAMPLES  = 1536;

  // bitrate and 44.1 khz word count for each pair of size codes
  localparam int PAIR_KBPS[19] = '{32, 40, 48, 56, 64, 80, 96, 112, 128, 160,
                                   192, 224, 256, 320, 384, 448, 512, 576, 640};
  localparam int PAIR_WORDS_44K1[19] = '{69, 87, 104, 121, 139, 174, 208, 243, 278, 348,
                                         417, 487, 557, 696, 835, 975, 1114, 1253, 1393};
  localparam int RATE_HZ[3]       = '{48000, 44100, 32000};
  localparam int MODE_CHANNELS[8] = '{2, 1, 2, 3, 3, 4, 4, 5};

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  ac3_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ac3_out_t out_data_o;

  ac3_out_t expected_headers[$];
  int       mismatch_count = 0;
  int       send_idle_pct  = 0;
  int       recv_idle_pct  = 0;
  logic     hold_output    = 1'b0;
  int       cycle_count    = 0;

  ac3_frame_header_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  // decoded header for one set of leading frame bytes
  function automatic ac3_out_t decode_header(input ac3_in_t hdr);
    ac3_out_t   res;
    logic [3:0] avail;
    logic [1:0] fs;
    logic [5:0] sc;
    logic [2:0] mode;
    logic [2:0] svc;
    int         shift;
    int         words;
    res   = '0;
    avail = (hdr.bytes_available > MIN_HEADER_BYTES) ? MIN_HEADER_BYTES : hdr.bytes_available;
    res.sync_ok = (avail >= MIN_SYNC_BYTES) && (hdr.sync_byte_high == SYNC_HIGH) &&
                  (hdr.sync_byte_low == SYNC_LOW);
    if (avail >= MIN_HEADER_BYTES) begin
      fs = hdr.rate_size_byte[7:6];
      sc = hdr.rate_size_byte[5:0];
      if (fs != RATE_RESERVED && sc < SIZE_CODES) begin
        // 48 khz words are twice the bitrate, 32 khz three times
        case (fs)
          RATE_48K:  words = 2 * PAIR_KBPS[sc[5:1]];
          RATE_44K1: words = PAIR_WORDS_44K1[sc[5:1]] + sc[0];
          default:   words = 3 * PAIR_KBPS[sc[5:1]];
        endcase
        res.header_ok    = 1'b1;
        res.frame_bytes  = 12'(2 * words);
        res.kbit_rate    = 10'(PAIR_KBPS[sc[5:1]]);
        res.rate_code    = fs;
        res.frame_micros = 16'((longint'(FRAME_SAMPLES) * 1000000 + RATE_HZ[fs] / 2) /
                               RATE_HZ[fs]);
      end
      svc  = hdr.stream_info_byte[2:0];
      mode = hdr.channel_mode_byte[7:5];
      // each optional mix field ahead of the lfe bit moves it down two places
      shift = 4;
      if (mode[0] && mode != MODE_MONO) shift -= 2;
      if (mode[2] || mode == MODE_STEREO) shift -= 2;
      res.stream_version = hdr.stream_info_byte[7:3];
      res.service_mode   = svc;
      res.channel_mode   = mode;
      res.full_channels  = 3'(MODE_CHANNELS[mode]);
      res.lfe_present    = hdr.channel_mode_byte[shift];
      res.main_service   = (svc < SVC_FIRST_ASSOC) || (svc == SVC_KARAOKE && mode > MODE_MONO);
    end
    return res;
  endfunction

  function automatic ac3_in_t make_header(input logic [3:0] avail, input logic [7:0] b0,
                                          input logic [7:0] b1, input logic [7:0] b4,
                                          input logic [7:0] b5, input logic [7:0] b6);
    ac3_in_t hdr;
    hdr.bytes_available   = avail;
    hdr.sync_byte_high    = b0;
    hdr.sync_byte_low     = b1;
    hdr.rate_size_byte    = b4;
    hdr.stream_info_byte  = b5;
    hdr.channel_mode_byte = b6;
    return hdr;
  endfunction

  // mostly complete headers with a good sync word and legal codes, the rest noise
  function automatic ac3_in_t random_header();
    ac3_in_t hdr;
    hdr.bytes_available   = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(8, 15))
                                                         : 4'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 70) begin
      hdr.sync_byte_high = SYNC_HIGH;
      hdr.sync_byte_low  = SYNC_LOW;
    end else begin
      hdr.sync_byte_high = 8'($urandom);
      hdr.sync_byte_low  = 8'($urandom);
    end
    if ($urandom_range(0, 99) < 75)
      hdr.rate_size_byte = {2'($urandom_range(0, 2)), 6'($urandom_range(0, SIZE_CODES - 1))};
    else
      hdr.rate_size_byte = 8'($urandom);
    hdr.stream_info_byte  = 8'($urandom);
    hdr.channel_mode_byte = 8'($urandom);
    return hdr;
  endfunction

  // offer one header and wait for its transfer
  task automatic send_header(input ac3_in_t hdr);
    int gap;
    gap = 0;
    while (gap < 50 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= hdr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_headers.push_back(decode_header(hdr));
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // output side: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    out_ready_i <= hold_output ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // compare each output transfer with the oldest expected header
  always @(posedge clk_i) begin
    ac3_out_t exp_hdr;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_headers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data_o);
        mismatch_count++;
      end else begin
        exp_hdr = expected_headers.pop_front();
        check_field("sync_ok",        exp_hdr.sync_ok,        out_data_o.sync_ok);
        check_field("header_ok",      exp_hdr.header_ok,      out_data_o.header_ok);
        check_field("frame_bytes",    exp_hdr.frame_bytes,    out_data_o.frame_bytes);
        check_field("kbit_rate",      exp_hdr.kbit_rate,      out_data_o.kbit_rate);
        check_field("rate_code",      exp_hdr.rate_code,      out_data_o.rate_code);
        check_field("frame_micros",   exp_hdr.frame_micros,   out_data_o.frame_micros);
        check_field("stream_version", exp_hdr.stream_version, out_data_o.stream_version);
        check_field("service_mode",   exp_hdr.service_mode,   out_data_o.service_mode);
        check_field("channel_mode",   exp_hdr.channel_mode,   out_data_o.channel_mode);
        check_field("full_channels",  exp_hdr.full_channels,  out_data_o.full_channels);
        check_field("lfe_present",    exp_hdr.lfe_present,    out_data_o.lfe_present);
        check_field("main_service",   exp_hdr.main_service,   out_data_o.main_service);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // field extremes, short headers, reserved codes and every channel mode
  task automatic test_directed_headers();
    logic [2:0] mode;
    send_header(make_header(4'd8, SYNC_HIGH, SYNC_LOW, {RATE_48K, 6'd0}, 8'h40, 8'h00));
    send_header(make_header(4'd0, SYNC_HIGH, SYNC_LOW, {RATE_48K, 6'd0}, 8'h40, 8'h40));
    send_header(make_header(4'd1, SYNC_HIGH, SYNC_LOW, {RATE_44K1, 6'd5}, 8'h41, 8'h50));
    send_header(make_header(4'd2, SYNC_HIGH, SYNC_LOW, {RATE_44K1, 6'd5}, 8'h41, 8'h50));
    send_header(make_header(4'd7, SYNC_HIGH, SYNC_LOW, {RATE_32K, 6'd9}, 8'hFF, 8'hFF));
    send_header(make_header(4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_header(make_header(4'd9, SYNC_HIGH, SYNC_LOW, {RATE_44K1, 6'd37}, 8'h42, 8'hF1));
    send_header(make_header(4'd8, SYNC_HIGH, SYNC_LOW, {RATE_32K, 6'd37}, 8'h43, 8'hE0));
    send_header(make_header(4'd8, SYNC_HIGH, SYNC_LOW, {RATE_32K, 6'd36}, 8'h44, 8'h3F));
    send_header(make_header(4'd8, SYNC_HIGH, SYNC_LOW, {RATE_48K, 6'd38}, 8'h45, 8'h7F));
    send_header(make_header(4'd8, SYNC_HIGH, SYNC_LOW, {RATE_RESERVED, 6'd0}, 8'h46, 8'h9A));
    // header decoding with a broken sync word
    send_header(make_header(4'd8, 8'h00, 8'h00, {RATE_44K1, 6'd20}, 8'h47, 8'hB5));
    send_header(make_header(4'd8, SYNC_LOW, SYNC_HIGH, {RATE_48K, 6'd1}, 8'h00, 8'h00));
    // each channel mode with the lfe bit set then clear, service mode following the mode
    for (int m = 0; m < 8; m++) begin
      mode = 3'(m);
      send_header(make_header(4'd8, SYNC_HIGH, SYNC_LOW, {RATE_48K, 6'(m)},
                              {5'd8, mode}, {mode, 5'b10101}));
      send_header(make_header(4'd8, SYNC_HIGH, SYNC_LOW, {RATE_32K, 6'(m + 8)},
                              {5'd31, mode}, {mode, 5'b01010}));
    end
    send_header(make_header(4'd8, SYNC_HIGH, SYNC_LOW, {RATE_48K, 6'd2},
                            {5'd8, SVC_KARAOKE}, {MODE_MONO, 5'b10000}));
    send_header(make_header(4'd8, SYNC_HIGH, SYNC_LOW, {RATE_48K, 6'd2},
                            {5'd8, SVC_KARAOKE}, {MODE_DUAL_MONO, 5'b10000}));
  endtask

  task automatic test_random_headers(input int count);
    repeat (count) send_header(random_header());
  endtask

  // output held off for a long stretch while headers keep coming
  task automatic test_output_hold_off();
    fork
      begin
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output <= 1'b0;
      end
      repeat (HOLD_ITEMS) send_header(random_header());
    join
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 63;
    test_directed_headers();
    test_random_headers(PHASE_ITEMS);

    send_idle_pct = 63;
    recv_idle_pct = 34;
    test_random_headers(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_headers(PHASE_ITEMS);
    test_output_hold_off();

    in_valid_i <= 1'b0;
    while (expected_headers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ac3_fhd_pkg.sv
rtl/ac3_frame_header_decoder.sv
bench/ac3_frame_header_decoder_tb.sv
